FILE: hw/rtl/obb2d_pkg.sv
`timescale 1ns / 1ps

package obb2d_pkg;

  localparam int CoordWidth   = 24;
  localparam int AxisFracBits = 14;
  localparam int AxisWidth    = 16;

  // Controller states: idle, centre difference, multiply, accumulate, compare, result.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_MUL,
    ST_ACC,
    ST_CMP,
    ST_OUT
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load;     // capture the incoming item
    logic       store;    // copy the item into the first-box registers
    logic       diff;     // form the centre differences
    logic       mul;      // issue one product step
    logic       acc;      // fold the product into the current axis sums
    logic       cmp;      // compare distance with limit on the current axis
    logic       clr;      // clear the separation flag
    logic       emit;     // load the verdict into the result register
    logic [1:0] axis;     // axis under test, 0..3
    logic [2:0] step;     // product step within one axis
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic role;
    logic hit;
  } sts_t;

endpackage

FILE: hw/rtl/obb2d_overlap_test_unit.sv
`timescale 1ns / 1ps
// Store items (box_role 0) give no result. Test items run four axes of eight
// products each through one shared multiplier, each product taking a multiply
// and an accumulate step. A test item holds the input until its verdict is
// loaded; the result sits in its own register, so only a finished test whose
// earlier result is still unread waits.
// Asynchronous active-low reset clears the stored box to a zero box at the origin.
module obb2d_overlap_test_unit #(
  parameter int COORD_WIDTH    = obb2d_pkg::CoordWidth,
  parameter int AXIS_FRAC_BITS = obb2d_pkg::AxisFracBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tdata: center_x, center_y, axis0_x, axis0_y, axis1_x, axis1_y, half_len0, half_len1
  input  logic [8*((4*COORD_WIDTH+4*obb2d_pkg::AxisWidth+5)/8)-1:0] s_axis_tdata,
  // tuser: box_role
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tdata: hit
  output logic [7:0] m_axis_tdata
);

  localparam int CW = COORD_WIDTH;
  localparam int AW = obb2d_pkg::AxisWidth;

  obb2d_pkg::cmd_t cmd;
  obb2d_pkg::sts_t sts;

  obb2d_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  obb2d_datapath #(
    .COORD_WIDTH    (COORD_WIDTH),
    .AXIS_FRAC_BITS (AXIS_FRAC_BITS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .role_i (s_axis_tuser),
    .cx_i   (s_axis_tdata[CW-1:0]),
    .cy_i   (s_axis_tdata[2*CW-1:CW]),
    .a0x_i  (s_axis_tdata[2*CW+AW-1:2*CW]),
    .a0y_i  (s_axis_tdata[2*CW+2*AW-1:2*CW+AW]),
    .a1x_i  (s_axis_tdata[2*CW+3*AW-1:2*CW+2*AW]),
    .a1y_i  (s_axis_tdata[2*CW+4*AW-1:2*CW+3*AW]),
    .l0_i   (s_axis_tdata[3*CW+4*AW-2:2*CW+4*AW]),
    .l1_i   (s_axis_tdata[4*CW+4*AW-3:3*CW+4*AW-1]),
    .sts_o  (sts)
  );

  assign m_axis_tdata = {7'd0, sts.hit};

endmodule

FILE: hw/rtl/obb2d_datapath.sv
`timescale 1ns / 1ps

module obb2d_datapath #(
  parameter int COORD_WIDTH    = obb2d_pkg::CoordWidth,
  parameter int AXIS_FRAC_BITS = obb2d_pkg::AxisFracBits
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  obb2d_pkg::cmd_t                       cmd_i,
  input  logic                                  role_i,
  input  logic signed [COORD_WIDTH-1:0]         cx_i,
  input  logic signed [COORD_WIDTH-1:0]         cy_i,
  input  logic signed [obb2d_pkg::AxisWidth-1:0] a0x_i,
  input  logic signed [obb2d_pkg::AxisWidth-1:0] a0y_i,
  input  logic signed [obb2d_pkg::AxisWidth-1:0] a1x_i,
  input  logic signed [obb2d_pkg::AxisWidth-1:0] a1y_i,
  input  logic [COORD_WIDTH-2:0]                l0_i,
  input  logic [COORD_WIDTH-2:0]                l1_i,
  output obb2d_pkg::sts_t                       sts_o
);

  localparam int AW = obb2d_pkg::AxisWidth;
  localparam int DW = COORD_WIDTH + 1;      // centre difference
  // Multiplier operand width: covers the centre difference and the magnitude
  // of an axis-to-axis dot product.
  localparam int MW = (DW > 2 * AW + 1) ? DW : 2 * AW + 1;
  localparam int PW = 2 * MW;               // product width
  localparam int SW = PW + 1;               // sum of two products
  localparam int RW = SW + COORD_WIDTH + 1; // radius and limit width

  // Stored first box and captured second box.
  logic signed [COORD_WIDTH-1:0] fcx_q, fcy_q, scx_q, scy_q;
  logic signed [AW-1:0] fax_q [2];
  logic signed [AW-1:0] fay_q [2];
  logic signed [AW-1:0] sax_q [2];
  logic signed [AW-1:0] say_q [2];
  logic [COORD_WIDTH-2:0] fl_q [2];
  logic [COORD_WIDTH-2:0] sl_q [2];
  logic role_q;
  logic signed [DW-1:0] lx_q, ly_q;

  // Shared multiplier operands and product.
  logic signed [MW-1:0] ma, mb;
  logic signed [PW-1:0] prod_q;
  logic [2:0] pstep_q;
  logic signed [SW-1:0] dot_q, d0_q, d1_q;
  logic [RW-1:0] rad_q;

  logic first_own;
  logic [0:0] k;
  logic signed [AW-1:0] ox, oy;          // axis under test
  logic signed [AW-1:0] bx0, by0, bx1, by1; // other box axes
  logic [COORD_WIDTH-2:0] own_len, bl0, bl1;
  logic [RW-1:0] limit, dist_mag;
  logic sep_q;
  logic hit_q;

  assign first_own = ~cmd_i.axis[1];
  assign k         = cmd_i.axis[0];

  // Select the axis under test and the other box.
  always_comb begin
    if (first_own) begin
      ox = fax_q[k]; oy = fay_q[k]; own_len = fl_q[k];
      bx0 = sax_q[0]; by0 = say_q[0]; bx1 = sax_q[1]; by1 = say_q[1];
      bl0 = sl_q[0]; bl1 = sl_q[1];
    end else begin
      ox = sax_q[k]; oy = say_q[k]; own_len = sl_q[k];
      bx0 = fax_q[0]; by0 = fay_q[0]; bx1 = fax_q[1]; by1 = fay_q[1];
      bl0 = fl_q[0]; bl1 = fl_q[1];
    end
  end

  // Operand selection for the product step in flight.
  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd_i.step)
      3'd0: begin ma = MW'(ox); mb = MW'(lx_q); end
      3'd1: begin ma = MW'(oy); mb = MW'(ly_q); end
      3'd2: begin ma = MW'(ox); mb = MW'(bx0); end
      3'd3: begin ma = MW'(oy); mb = MW'(by0); end
      3'd4: begin ma = MW'(ox); mb = MW'(bx1); end
      3'd5: begin ma = MW'(oy); mb = MW'(by1); end
      3'd6: begin ma = MW'(d0_q < 0 ? -d0_q : d0_q); mb = MW'({1'b0, bl0}); end
      3'd7: begin ma = MW'(d1_q < 0 ? -d1_q : d1_q); mb = MW'({1'b0, bl1}); end
      default: ;
    endcase
  end

  assign dist_mag = RW'(dot_q < 0 ? -dot_q : dot_q);
  assign limit    = (RW'(own_len) << AXIS_FRAC_BITS) + (rad_q >> AXIS_FRAC_BITS);

  // Reset registers: stored first box, separation flag and result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fcx_q <= '0; fcy_q <= '0;
      fax_q[0] <= '0; fax_q[1] <= '0; fay_q[0] <= '0; fay_q[1] <= '0;
      fl_q[0] <= '0; fl_q[1] <= '0;
      sep_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      if (cmd_i.store) begin
        fcx_q <= scx_q; fcy_q <= scy_q;
        fax_q <= sax_q; fay_q <= say_q; fl_q <= sl_q;
      end
      if (cmd_i.clr) sep_q <= 1'b0;
      else if (cmd_i.cmp && (dist_mag > limit)) sep_q <= 1'b1;
      // The result register keeps the verdict while the next item is worked on.
      if (cmd_i.emit) hit_q <= ~sep_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      role_q <= role_i;
      scx_q <= cx_i; scy_q <= cy_i;
      sax_q[0] <= a0x_i; say_q[0] <= a0y_i;
      sax_q[1] <= a1x_i; say_q[1] <= a1y_i;
      sl_q[0] <= l0_i; sl_q[1] <= l1_i;
    end
    if (cmd_i.diff) begin
      lx_q <= DW'(fcx_q) - DW'(scx_q);
      ly_q <= DW'(fcy_q) - DW'(scy_q);
    end
    if (cmd_i.mul) begin
      prod_q  <= ma * mb;
      pstep_q <= cmd_i.step;
    end
    if (cmd_i.acc) begin
      case (pstep_q)
        3'd0: dot_q <= SW'(prod_q);
        3'd1: dot_q <= dot_q + SW'(prod_q);
        3'd2: d0_q  <= SW'(prod_q);
        3'd3: d0_q  <= d0_q + SW'(prod_q);
        3'd4: d1_q  <= SW'(prod_q);
        3'd5: d1_q  <= d1_q + SW'(prod_q);
        3'd6: rad_q <= RW'($unsigned(prod_q));
        3'd7: rad_q <= rad_q + RW'($unsigned(prod_q));
        default: ;
      endcase
    end
  end

  assign sts_o.role = role_q;
  assign sts_o.hit  = hit_q;

endmodule

FILE: hw/rtl/obb2d_ctrl.sv
`timescale 1ns / 1ps

module obb2d_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  obb2d_pkg::sts_t sts_i,
  output obb2d_pkg::cmd_t cmd_o
);

  obb2d_pkg::state_e state_q, state_d;
  logic [1:0] axis_q, axis_d;
  logic [2:0] step_q, step_d;
  logic       outv_q, outv_d;
  logic       out_free;

  // The result register can take a new verdict when it is empty or being read.
  assign out_free = !outv_q || out_ready_i;

  // Next state: each axis issues eight products, each followed by an accumulate.
  always_comb begin
    state_d = state_q;
    axis_d  = axis_q;
    step_d  = step_q;
    case (state_q)
      obb2d_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = obb2d_pkg::ST_DIFF;
        end
      end
      obb2d_pkg::ST_DIFF: begin
        if (!sts_i.role) state_d = obb2d_pkg::ST_IDLE;
        else begin
          state_d = obb2d_pkg::ST_MUL;
          axis_d  = '0;
          step_d  = '0;
        end
      end
      obb2d_pkg::ST_MUL: state_d = obb2d_pkg::ST_ACC;
      obb2d_pkg::ST_ACC: begin
        step_d = step_q + 3'd1;
        if (step_q == 3'd7) state_d = obb2d_pkg::ST_CMP;
        else                state_d = obb2d_pkg::ST_MUL;
      end
      obb2d_pkg::ST_CMP: begin
        axis_d = axis_q + 2'd1;
        if (axis_q == 2'd3) state_d = obb2d_pkg::ST_OUT;
        else                state_d = obb2d_pkg::ST_MUL;
      end
      obb2d_pkg::ST_OUT: begin
        if (out_free) state_d = obb2d_pkg::ST_IDLE;
      end
      default: state_d = obb2d_pkg::ST_IDLE;
    endcase
  end

  // Result valid: held until the downstream side takes the transaction.
  always_comb begin
    outv_d = outv_q;
    if (out_ready_i) outv_d = 1'b0;
    if ((state_q == obb2d_pkg::ST_OUT) && out_free) outv_d = 1'b1;
  end

  // Command outputs.
  always_comb begin
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    cmd_o.step  = step_q;
    in_ready_o  = 1'b0;
    case (state_q)
      obb2d_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      obb2d_pkg::ST_DIFF: begin
        cmd_o.store = !sts_i.role;
        cmd_o.diff  = sts_i.role;
        cmd_o.clr   = 1'b1;
      end
      obb2d_pkg::ST_MUL: cmd_o.mul = 1'b1;
      obb2d_pkg::ST_ACC: cmd_o.acc = 1'b1;
      obb2d_pkg::ST_CMP: cmd_o.cmp = 1'b1;
      obb2d_pkg::ST_OUT: cmd_o.emit = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= obb2d_pkg::ST_IDLE;
      axis_q  <= '0;
      step_q  <= '0;
      outv_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
      step_q  <= step_d;
      outv_q  <= outv_d;
    end
  end

  assign out_valid_o = outv_q;

endmodule

FILE: hw/rtl/obb2d_checker.sv
`timescale 1ns / 1ps

module obb2d_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata
);

  // A waiting result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // A result stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result withdrawn before it was taken");

  // Right after an accepted item the block is busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("block not busy after accept");

  // Only the hit bit may be set.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
    else $error("padding bits set");

endmodule

bind obb2d_overlap_test_unit obb2d_checker u_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
